@@ hw/rtl/bdtm_pkg.sv @@
// Shared types, constants and helper functions of the box dimension template matcher.
// Used by every module of the block; depends on nothing else.
package bdtm_pkg;

   localparam int COORD_BITS     = 16;
   localparam int MAX_CLUSTERS   = 256;
   localparam int EXT_BITS       = 16;
   localparam int COUNT_BITS     = 24;
   localparam int CLUSTER_BITS   = 8;
   localparam int PROD_BITS      = 32;
   localparam int SCORE_BITS     = 34;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam int EXT_MAX       = (1 << EXT_BITS) - 1;
   localparam int CLUSTER_LIMIT = (MAX_CLUSTERS - 1 > 255) ? 255 : (MAX_CLUSTERS - 1);

   localparam logic [COUNT_BITS-1:0]    COUNT_MAX     = '1;
   localparam logic [CSR_DATA_BITS-1:0] EXP_SMALL_RST = 16'd160;
   localparam logic [CSR_DATA_BITS-1:0] EXP_MID_RST   = 16'd850;
   localparam logic [CSR_DATA_BITS-1:0] EXP_LARGE_RST = 16'd1000;
   localparam logic [CSR_DATA_BITS-1:0] FAC_SMALL_RST = 16'd655;
   localparam logic [CSR_DATA_BITS-1:0] FAC_MID_RST   = 16'd393;
   localparam logic [CSR_DATA_BITS-1:0] FAC_LARGE_RST = 16'd655;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET_SMALL  = 3'd0,
      CSR_TARGET_MIDDLE = 3'd1,
      CSR_TARGET_LARGE  = 3'd2,
      CSR_FACTOR_SMALL  = 3'd3,
      CSR_FACTOR_MIDDLE = 3'd4,
      CSR_FACTOR_LARGE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      coord_type coord_x;
      coord_type coord_y;
      coord_type coord_z;
      logic      last_in_cluster;
      logic      last_in_set;
   } req_data_type;

   typedef struct packed {
      logic [CLUSTER_BITS-1:0] cluster_number;
      logic [COUNT_BITS-1:0]   point_count;
      logic [EXT_BITS-1:0]     extent_small;
      logic [EXT_BITS-1:0]     extent_middle;
      logic [EXT_BITS-1:0]     extent_large;
      logic [SCORE_BITS-1:0]   match_score;
      logic [CLUSTER_BITS-1:0] best_cluster;
      logic [SCORE_BITS-1:0]   best_score;
      logic                    set_done;
   } rsp_data_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] target_small;
      logic [CSR_DATA_BITS-1:0] target_middle;
      logic [CSR_DATA_BITS-1:0] target_large;
      logic [CSR_DATA_BITS-1:0] factor_small;
      logic [CSR_DATA_BITS-1:0] factor_middle;
      logic [CSR_DATA_BITS-1:0] factor_large;
   } cfg_type;

   // Final bounding box corners of one cluster.
   typedef struct packed {
      logic [CLUSTER_BITS-1:0] cluster_number;
      logic [COUNT_BITS-1:0]   point_count;
      coord_type [2:0]         low_corner;
      coord_type [2:0]         high_corner;
      logic                    set_done;
   } corner_beat_type;

   typedef struct packed {
      logic [CLUSTER_BITS-1:0]      cluster_number;
      logic [COUNT_BITS-1:0]        point_count;
      logic [2:0][EXT_BITS-1:0]     extent;
      logic                         set_done;
   } extent_beat_type;

   typedef struct packed {
      extent_beat_type              info;
      logic [2:0][PROD_BITS-1:0]    product;
   } product_beat_type;

   typedef struct packed {
      extent_beat_type              info;
      logic [SCORE_BITS-1:0]        score;
   } score_beat_type;

   // Extent along one axis, saturated to the extent field.
   function automatic logic [EXT_BITS-1:0] axis_extent(coord_type low, coord_type high);
      logic [COORD_BITS:0] diff;
      diff = (COORD_BITS+1)'($signed(high)) - (COORD_BITS+1)'($signed(low));
      if (diff > (COORD_BITS+1)'(EXT_MAX)) begin
         return EXT_BITS'(EXT_MAX);
      end
      return EXT_BITS'(diff);
   endfunction

   // |extent - expected| times a Q0.16 factor.
   function automatic logic [PROD_BITS-1:0] weighted_error(logic [EXT_BITS-1:0] ext,
                                                          logic [CSR_DATA_BITS-1:0] expected,
                                                          logic [CSR_DATA_BITS-1:0] factor);
      logic [EXT_BITS-1:0] d;
      d = (ext >= expected) ? (ext - expected) : (expected - ext);
      return PROD_BITS'(d) * PROD_BITS'(factor);
   endfunction

endpackage

@@ hw/rtl/box_dimension_template_matcher.sv @@
// Box dimension template matcher: point stream in, one scored box per cluster out.
// Uses bdtm_pkg, bdtm_accum, bdtm_score and bdtm_select.
//
// Usage: points enter on the req_ channel, one beat per point, with flags for the
// last point of a cluster and the last cluster of a set. Each cluster end yields
// one rsp_ beat with the sorted box extents, the cluster score and the best
// cluster of the set so far; set_done marks the beat whose best is final.
// Points that do not end a cluster give no result.
// Throughput is one point per clock while req_stall is low. The result of a cluster
// passes through these registers in order before it can be taken on rsp_: input
// register, corner capture, extent, sort, weighted error multiply, sum, and the
// compare in the result register.
// A stall on rsp_ holds the result register; the stages behind it fill their
// empty slots first, then req_stall rises. Ordinary points keep flowing while
// only their accumulator is touched.
// The csr_ port writes the expected extents and factors; it is always ready and
// is meant to be written while no point is in flight. Synchronous reset loads
// the default box, clears the corners, counts and best-cluster state.
module box_dimension_template_matcher (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  bdtm_pkg::req_data_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bdtm_pkg::rsp_data_type                 rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bdtm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bdtm_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import bdtm_pkg::*;

   cfg_type         cfg_ff;
   corner_beat_type corner_data;
   score_beat_type  score_data;
   logic            corner_valid, corner_ready;
   logic            score_valid, score_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_small  <= EXP_SMALL_RST;
         cfg_ff.target_middle <= EXP_MID_RST;
         cfg_ff.target_large  <= EXP_LARGE_RST;
         cfg_ff.factor_small  <= FAC_SMALL_RST;
         cfg_ff.factor_middle <= FAC_MID_RST;
         cfg_ff.factor_large  <= FAC_LARGE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TARGET_SMALL:  cfg_ff.target_small  <= csr_data;
            CSR_TARGET_MIDDLE: cfg_ff.target_middle <= csr_data;
            CSR_TARGET_LARGE:  cfg_ff.target_large  <= csr_data;
            CSR_FACTOR_SMALL:  cfg_ff.factor_small  <= csr_data;
            CSR_FACTOR_MIDDLE: cfg_ff.factor_middle <= csr_data;
            CSR_FACTOR_LARGE:  cfg_ff.factor_large  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   bdtm_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .corner_valid (corner_valid),
      .corner_ready (corner_ready),
      .corner_data  (corner_data)
   );

   bdtm_score u_score (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .corner_valid (corner_valid),
      .corner_ready (corner_ready),
      .corner_data  (corner_data),
      .score_valid  (score_valid),
      .score_ready  (score_ready),
      .score_data   (score_data)
   );

   bdtm_select u_select (
      .clock       (clock),
      .reset       (reset),
      .score_valid (score_valid),
      .score_ready (score_ready),
      .score_data  (score_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // The best score of a set can never exceed the score just reported.
   a_best_not_worse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.best_score <= rsp_data.match_score))
      else $error("best score above current cluster score");

   // Extents leave the sort stage in ascending order.
   a_extents_sorted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.extent_small <= rsp_data.extent_middle)
                  && (rsp_data.extent_middle <= rsp_data.extent_large)))
      else $error("extents out of order");

   // The best cluster is never later in the set than the one being reported.
   a_best_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.best_cluster <= rsp_data.cluster_number))
      else $error("best cluster index ahead of current cluster");

endmodule

@@ hw/rtl/bdtm_accum.sv @@
// Input register and per-cluster bounding box accumulator of the box matcher.
// Depends on bdtm_pkg; hands one corner beat per finished cluster to bdtm_score.
module bdtm_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bdtm_pkg::req_data_type    req_data,
   output logic                      corner_valid,
   input  logic                      corner_ready,
   output bdtm_pkg::corner_beat_type corner_data
);
   import bdtm_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   req_data_type            in_data_ff;
   coord_type               low_ff  [3];
   coord_type               high_ff [3];
   coord_type               low_in  [3];
   coord_type               high_in [3];
   coord_type               coord   [3];
   logic [COUNT_BITS-1:0]   count_ff, count_in, count_next;
   logic [CLUSTER_BITS-1:0] cluster_ff, cluster_in;
   logic                    corner_valid_ff, corner_valid_in;
   corner_beat_type         corner_data_ff, corner_data_in;
   logic                    accept, consume, close, corner_free;

   assign coord[0] = in_data_ff.coord_x;
   assign coord[1] = in_data_ff.coord_y;
   assign coord[2] = in_data_ff.coord_z;

   // A point that ends a cluster waits until the corner register is free.
   assign corner_free = !corner_valid_ff || corner_ready;
   assign consume     = in_valid_ff && (!in_data_ff.last_in_cluster || corner_free);
   assign close       = consume && in_data_ff.last_in_cluster;
   assign req_stall   = in_valid_ff && !consume;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !consume);

   assign count_next = (count_ff == COUNT_MAX) ? count_ff : (count_ff + 1'b1);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         low_in[k]  = ($signed(coord[k]) < $signed(low_ff[k]))  ? coord[k] : low_ff[k];
         high_in[k] = ($signed(coord[k]) > $signed(high_ff[k])) ? coord[k] : high_ff[k];
      end

      corner_data_in.cluster_number = cluster_ff;
      corner_data_in.point_count    = count_next;
      for (int k = 0; k < 3; k++) begin
         corner_data_in.low_corner[k]  = low_in[k];
         corner_data_in.high_corner[k] = high_in[k];
      end
      corner_data_in.set_done = in_data_ff.last_in_set;

      count_in   = count_next;
      cluster_in = cluster_ff;
      if (close) begin
         count_in = '0;
         if (in_data_ff.last_in_set) begin
            cluster_in = '0;
         end else if (cluster_ff < CLUSTER_BITS'(CLUSTER_LIMIT)) begin
            cluster_in = cluster_ff + 1'b1;
         end
      end

      corner_valid_in = close ? 1'b1 : (corner_ready ? 1'b0 : corner_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         corner_valid_ff <= 1'b0;
         count_ff        <= '0;
         cluster_ff      <= '0;
         for (int k = 0; k < 3; k++) begin
            low_ff[k]  <= COORD_MAX;
            high_ff[k] <= COORD_MIN;
         end
      end else begin
         in_valid_ff     <= in_valid_in;
         corner_valid_ff <= corner_valid_in;
         if (consume) begin
            count_ff   <= count_in;
            cluster_ff <= cluster_in;
            for (int k = 0; k < 3; k++) begin
               low_ff[k]  <= close ? COORD_MAX : low_in[k];
               high_ff[k] <= close ? COORD_MIN : high_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (close) begin
         corner_data_ff <= corner_data_in;
      end
   end

   assign corner_valid = corner_valid_ff;
   assign corner_data  = corner_data_ff;

endmodule

@@ hw/rtl/bdtm_score.sv @@
// Extent, sort, weighted error and sum stages of the box matcher.
// Depends on bdtm_pkg; takes corner beats from bdtm_accum, feeds bdtm_select.
module bdtm_score (
   input  logic                      clock,
   input  logic                      reset,
   input  bdtm_pkg::cfg_type         cfg,
   input  logic                      corner_valid,
   output logic                      corner_ready,
   input  bdtm_pkg::corner_beat_type corner_data,
   output logic                      score_valid,
   input  logic                      score_ready,
   output bdtm_pkg::score_beat_type  score_data
);
   import bdtm_pkg::*;

   logic             ext_valid_ff, sort_valid_ff, prod_valid_ff, sum_valid_ff;
   extent_beat_type  ext_ff, ext_in, sort_ff, sort_in;
   product_beat_type prod_ff, prod_in;
   score_beat_type   sum_ff, sum_in;
   logic             ext_rdy, sort_rdy, prod_rdy, sum_rdy;
   logic [EXT_BITS-1:0] swap;

   // Each stage moves on when it is empty or its successor moves on.
   assign sum_rdy      = !sum_valid_ff  || score_ready;
   assign prod_rdy     = !prod_valid_ff || sum_rdy;
   assign sort_rdy     = !sort_valid_ff || prod_rdy;
   assign ext_rdy      = !ext_valid_ff  || sort_rdy;
   assign corner_ready = ext_rdy;

   always_comb begin
      ext_in.cluster_number = corner_data.cluster_number;
      ext_in.point_count    = corner_data.point_count;
      ext_in.set_done       = corner_data.set_done;
      for (int k = 0; k < 3; k++) begin
         ext_in.extent[k] = axis_extent(corner_data.low_corner[k],
                                        corner_data.high_corner[k]);
      end
   end

   // Three compare-exchange steps put the extents in ascending order.
   always_comb begin
      swap    = '0;
      sort_in = ext_ff;
      if (sort_in.extent[0] > sort_in.extent[1]) begin
         swap              = sort_in.extent[0];
         sort_in.extent[0] = sort_in.extent[1];
         sort_in.extent[1] = swap;
      end
      if (sort_in.extent[1] > sort_in.extent[2]) begin
         swap              = sort_in.extent[1];
         sort_in.extent[1] = sort_in.extent[2];
         sort_in.extent[2] = swap;
      end
      if (sort_in.extent[0] > sort_in.extent[1]) begin
         swap              = sort_in.extent[0];
         sort_in.extent[0] = sort_in.extent[1];
         sort_in.extent[1] = swap;
      end
   end

   always_comb begin
      prod_in.info       = sort_ff;
      prod_in.product[0] = weighted_error(sort_ff.extent[0], cfg.target_small,
                                          cfg.factor_small);
      prod_in.product[1] = weighted_error(sort_ff.extent[1], cfg.target_middle,
                                          cfg.factor_middle);
      prod_in.product[2] = weighted_error(sort_ff.extent[2], cfg.target_large,
                                          cfg.factor_large);
   end

   always_comb begin
      sum_in.info  = prod_ff.info;
      sum_in.score = SCORE_BITS'(prod_ff.product[0]) + SCORE_BITS'(prod_ff.product[1])
                   + SCORE_BITS'(prod_ff.product[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_valid_ff  <= 1'b0;
         sort_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (ext_rdy) begin
            ext_valid_ff <= corner_valid;
         end
         if (sort_rdy) begin
            sort_valid_ff <= ext_valid_ff;
         end
         if (prod_rdy) begin
            prod_valid_ff <= sort_valid_ff;
         end
         if (sum_rdy) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ext_rdy) begin
         ext_ff <= ext_in;
      end
      if (sort_rdy) begin
         sort_ff <= sort_in;
      end
      if (prod_rdy) begin
         prod_ff <= prod_in;
      end
      if (sum_rdy) begin
         sum_ff <= sum_in;
      end
   end

   assign score_valid = sum_valid_ff;
   assign score_data  = sum_ff;

endmodule

@@ hw/rtl/bdtm_select.sv @@
// Best-cluster tracking and result register of the box matcher.
// Depends on bdtm_pkg; takes score beats from bdtm_score and drives the rsp_ channel.
module bdtm_select (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     score_valid,
   output logic                     score_ready,
   input  bdtm_pkg::score_beat_type score_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bdtm_pkg::rsp_data_type   rsp_data
);
   import bdtm_pkg::*;

   logic                    out_valid_ff;
   rsp_data_type            out_data_ff, out_data_in;
   logic                    have_best_ff;
   logic [CLUSTER_BITS-1:0] best_index_ff, best_index_in;
   logic [SCORE_BITS-1:0]   best_value_ff, best_value_in;
   logic                    load, take, better;

   assign load        = !out_valid_ff || !rsp_stall;
   assign score_ready = load;
   assign take        = load && score_valid;

   // Ties keep the earlier cluster.
   assign better        = !have_best_ff || (score_data.score < best_value_ff);
   assign best_index_in = better ? score_data.info.cluster_number : best_index_ff;
   assign best_value_in = better ? score_data.score : best_value_ff;

   always_comb begin
      out_data_in.cluster_number = score_data.info.cluster_number;
      out_data_in.point_count    = score_data.info.point_count;
      out_data_in.extent_small   = score_data.info.extent[0];
      out_data_in.extent_middle  = score_data.info.extent[1];
      out_data_in.extent_large   = score_data.info.extent[2];
      out_data_in.match_score    = score_data.score;
      out_data_in.best_cluster   = best_index_in;
      out_data_in.best_score     = best_value_in;
      out_data_in.set_done       = score_data.info.set_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         have_best_ff  <= 1'b0;
         best_index_ff <= '0;
         best_value_ff <= '0;
      end else begin
         if (load) begin
            out_valid_ff <= score_valid;
         end
         if (take) begin
            if (score_data.info.set_done) begin
               have_best_ff  <= 1'b0;
               best_index_ff <= '0;
               best_value_ff <= '0;
            end else begin
               have_best_ff  <= 1'b1;
               best_index_ff <= best_index_in;
               best_value_ff <= best_value_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ tb/sv/box_match_checker.sv @@
// Checker for the box dimension template matcher: predicts every cluster result from the
// point beats and register writes it sees, and compares the result beats field by field.
// Depends on bdtm_pkg for the payload, register index and reset value definitions.
module box_match_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  bdtm_pkg::req_data_type              req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  bdtm_pkg::rsp_data_type              rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [bdtm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bdtm_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  points_seen_total,
   output int                                  boxes_checked,
   output int                                  sets_closed
);
   timeunit 1ns;
   timeprecision 1ps;
   import bdtm_pkg::*;

   localparam int CLUSTER_CEILING = 255;
   localparam logic [23:0] POINT_CEILING = 24'hFF_FFFF;

   cfg_type      box_cfg;
   coord_type    box_low[3];
   coord_type    box_high[3];
   logic [23:0]  points_in_box;
   logic [7:0]   cluster_slot;
   logic [7:0]   winner_slot;
   logic [33:0]  winner_score;
   logic         winner_known;
   rsp_data_type boxes_due[$];

   initial begin
      fail_count = 0;
      pending_count = 0;
      points_seen_total = 0;
      boxes_checked = 0;
      sets_closed = 0;
   end

   task automatic empty_box();
      int k;
      for (k = 0; k < 3; k++) begin
         box_low[k]  = COORD_MAX;
         box_high[k] = COORD_MIN;
      end
      points_in_box = '0;
   endtask

   task automatic forget_winner();
      cluster_slot = '0;
      winner_slot  = '0;
      winner_score = '0;
      winner_known = 1'b0;
   endtask

   // Folds one point into the running box and, on a cluster end, queues the result.
   task automatic absorb_point(input req_data_type p);
      coord_type       c[3];
      int              span[3];
      int              goal[3];
      int              weight[3];
      int              gap;
      int              hold;
      int              k;
      longint unsigned total;
      logic [33:0]     score;
      rsp_data_type    box;
      c[0] = p.coord_x;
      c[1] = p.coord_y;
      c[2] = p.coord_z;
      for (k = 0; k < 3; k++) begin
         if (c[k] < box_low[k]) box_low[k] = c[k];
         if (c[k] > box_high[k]) box_high[k] = c[k];
      end
      if (points_in_box != POINT_CEILING) points_in_box++;
      if (!p.last_in_cluster) return;

      for (k = 0; k < 3; k++) begin
         span[k] = int'(box_high[k]) - int'(box_low[k]);
         if (span[k] > 65535) span[k] = 65535;
      end
      if (span[0] > span[1]) begin hold = span[0]; span[0] = span[1]; span[1] = hold; end
      if (span[1] > span[2]) begin hold = span[1]; span[1] = span[2]; span[2] = hold; end
      if (span[0] > span[1]) begin hold = span[0]; span[0] = span[1]; span[1] = hold; end

      goal[0]   = int'(box_cfg.target_small);
      goal[1]   = int'(box_cfg.target_middle);
      goal[2]   = int'(box_cfg.target_large);
      weight[0] = int'(box_cfg.factor_small);
      weight[1] = int'(box_cfg.factor_middle);
      weight[2] = int'(box_cfg.factor_large);
      total = 0;
      for (k = 0; k < 3; k++) begin
         gap = span[k] - goal[k];
         if (gap < 0) gap = -gap;
         total += longint'(gap) * longint'(weight[k]);
      end
      score = total[33:0];

      // A tie keeps the earlier cluster as the winner.
      if (!winner_known || score < winner_score) begin
         winner_known = 1'b1;
         winner_score = score;
         winner_slot  = cluster_slot;
      end

      box.cluster_number = cluster_slot;
      box.point_count    = points_in_box;
      box.extent_small   = span[0][15:0];
      box.extent_middle  = span[1][15:0];
      box.extent_large   = span[2][15:0];
      box.match_score    = score;
      box.best_cluster   = winner_slot;
      box.best_score     = winner_score;
      box.set_done       = p.last_in_set;
      boxes_due = {boxes_due, box};

      if (cluster_slot < CLUSTER_CEILING) cluster_slot++;
      empty_box();
      if (p.last_in_set) forget_winner();
   endtask

   task automatic check_field(input string field, input logic [33:0] want,
                              input logic [33:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_data_type want;
      if (reset) begin
         box_cfg.target_small  = EXP_SMALL_RST;
         box_cfg.target_middle = EXP_MID_RST;
         box_cfg.target_large  = EXP_LARGE_RST;
         box_cfg.factor_small  = FAC_SMALL_RST;
         box_cfg.factor_middle = FAC_MID_RST;
         box_cfg.factor_large  = FAC_LARGE_RST;
         empty_box();
         forget_winner();
         boxes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_TARGET_SMALL:  box_cfg.target_small  = csr_data;
               CSR_TARGET_MIDDLE: box_cfg.target_middle = csr_data;
               CSR_TARGET_LARGE:  box_cfg.target_large  = csr_data;
               CSR_FACTOR_SMALL:  box_cfg.factor_small  = csr_data;
               CSR_FACTOR_MIDDLE: box_cfg.factor_middle = csr_data;
               CSR_FACTOR_LARGE:  box_cfg.factor_large  = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (boxes_due.size() == 0) begin
               $display("%0t ns: result beat with no cluster pending, expected none, got %p",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = boxes_due.pop_front();
               check_field("cluster_number", want.cluster_number, rsp_data.cluster_number);
               check_field("point_count", want.point_count, rsp_data.point_count);
               check_field("extent_small", want.extent_small, rsp_data.extent_small);
               check_field("extent_middle", want.extent_middle, rsp_data.extent_middle);
               check_field("extent_large", want.extent_large, rsp_data.extent_large);
               check_field("match_score", want.match_score, rsp_data.match_score);
               check_field("best_cluster", want.best_cluster, rsp_data.best_cluster);
               check_field("best_score", want.best_score, rsp_data.best_score);
               check_field("set_done", want.set_done, rsp_data.set_done);
               boxes_checked++;
               if (want.set_done) sets_closed++;
            end
         end
         if (req_valid && !req_stall) begin
            absorb_point(req_data);
            points_seen_total++;
         end
      end
      pending_count <= boxes_due.size();
   end

endmodule

@@ tb/sv/tb.sv @@
// Top of the box dimension template matcher testbench: clock, reset, point and register
// stimulus, result-side stalls and the verdict. Depends on bdtm_pkg, the block and
// box_match_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bdtm_pkg::*;

   typedef enum {CLOUD_TEMPLATE, CLOUD_TIGHT, CLOUD_WILD} cloud_kind_type;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_POINTS = 280;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_data_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_data_type  rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_TARGET_SMALL;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int      fail_count;
   int      pending_count;
   int      points_seen_total;
   int      boxes_checked;
   int      sets_closed;
   int      cycle_count = 0;
   int      items_sent = 0;
   logic    calm = 1'b0;
   cfg_type box_goal;

   box_dimension_template_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   box_match_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .points_seen_total (points_seen_total),
      .boxes_checked     (boxes_checked),
      .sets_closed       (sets_closed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 22);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL box_dimension_template_matcher");
         $finish;
      end
   end

   function automatic req_data_type point(input int x, input int y, input int z,
                                          input bit ends_cluster, input bit ends_set);
      req_data_type p;
      p.coord_x         = coord_type'(x);
      p.coord_y         = coord_type'(y);
      p.coord_z         = coord_type'(z);
      p.last_in_cluster = ends_cluster;
      p.last_in_set     = ends_set;
      return p;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_setting();
      case ($urandom_range(3))
         0: return CSR_DATA_BITS'($urandom_range(65535));
         1: return CSR_DATA_BITS'($urandom_range(255));
         default: return CSR_DATA_BITS'($urandom_range(2000));
      endcase
   endfunction

   task automatic send_point(input req_data_type p);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   // Drops valid, waits for every queued result, then lets points with no result drain.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic program_box(input cfg_type c);
      write_reg(CSR_TARGET_SMALL, c.target_small);
      write_reg(CSR_TARGET_MIDDLE, c.target_middle);
      write_reg(CSR_TARGET_LARGE, c.target_large);
      write_reg(CSR_FACTOR_SMALL, c.factor_small);
      write_reg(CSR_FACTOR_MIDDLE, c.factor_middle);
      write_reg(CSR_FACTOR_LARGE, c.factor_large);
      csr_valid <= 1'b0;
      box_goal = c;
      @(posedge clock);
   endtask

   // Streams one cluster of n points; but for CLOUD_WILD, the box corners land on two random points.
   task automatic send_cluster(input int n, input bit ends_set, input cloud_kind_type kind);
      int  dims[3];
      int  base[3];
      int  c[3];
      int  low_at;
      int  high_at;
      int  hold;
      int  i;
      int  k;
      bit  ends_cluster;
      dims[0] = int'(box_goal.target_small);
      dims[1] = int'(box_goal.target_middle);
      dims[2] = int'(box_goal.target_large);
      for (k = 0; k < 3; k++) begin
         if (kind == CLOUD_TIGHT) begin
            dims[k] = $urandom_range(300);
         end else if ($urandom_range(9) == 0) begin
            dims[k] = $urandom_range(65535);
         end else begin
            dims[k] = dims[k] + int'($urandom_range(600)) - 300;
         end
         if (dims[k] < 0) dims[k] = 0;
         if (dims[k] > 65535) dims[k] = 65535;
      end
      // Hand the sizes to the axes in a random order so the sort is exercised.
      for (i = 0; i < 2; i++) begin
         k = $urandom_range(2);
         hold = dims[k];
         dims[k] = dims[2 - i];
         dims[2 - i] = hold;
      end
      for (k = 0; k < 3; k++) base[k] = int'($urandom_range(65535 - dims[k])) - 32768;
      low_at  = $urandom_range(n - 1);
      high_at = (n > 1) ? (low_at + 1 + int'($urandom_range(n - 2))) % n : low_at;
      for (i = 0; i < n; i++) begin
         for (k = 0; k < 3; k++) begin
            if (kind == CLOUD_WILD) c[k] = int'($urandom_range(65535)) - 32768;
            else if (i == low_at) c[k] = base[k];
            else if (i == high_at) c[k] = base[k] + dims[k];
            else c[k] = base[k] + int'($urandom_range(dims[k]));
         end
         ends_cluster = (i == n - 1);
         // A stray set flag on an inner point must be ignored.
         send_point(point(c[0], c[1], c[2], ends_cluster,
                          ends_cluster ? ends_set : ($urandom_range(9) == 0)));
      end
   endtask

   task automatic send_set(input int clusters);
      int j;
      int n;
      int roll;
      cloud_kind_type kind;
      for (j = 0; j < clusters; j++) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(30, 7) : $urandom_range(6, 1);
         roll = $urandom_range(9);
         kind = (roll < 6) ? CLOUD_TEMPLATE : (roll < 8) ? CLOUD_TIGHT : CLOUD_WILD;
         send_cluster(n, j == clusters - 1, kind);
      end
   endtask

   initial begin : stimulus
      cfg_type setting;
      int      phase;
      int      target;
      int      j;
      box_goal.target_small  = EXP_SMALL_RST;
      box_goal.target_middle = EXP_MID_RST;
      box_goal.target_large  = EXP_LARGE_RST;
      box_goal.factor_small  = FAC_SMALL_RST;
      box_goal.factor_middle = FAC_MID_RST;
      box_goal.factor_large  = FAC_LARGE_RST;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets under the reset box: corner coordinates, a stray set flag, an exact
      // match, a tied permuted match, the set close and a second short set with its close.
      send_point(point(-32768, -32768, -32768, 1'b1, 1'b0));
      send_point(point(32767, 32767, 32767, 1'b0, 1'b1));
      send_point(point(-32768, 0, -1, 1'b1, 1'b0));
      send_point(point(0, 0, 0, 1'b0, 1'b0));
      send_point(point(160, 850, 1000, 1'b1, 1'b0));
      send_point(point(1000, 0, 160, 1'b0, 1'b0));
      send_point(point(0, 850, 0, 1'b1, 1'b0));
      send_point(point(5, 5, 5, 1'b1, 1'b1));
      send_point(point(100, 200, 300, 1'b0, 1'b0));
      send_point(point(-60, -650, -700, 1'b1, 1'b0));
      send_point(point(-1, 1, 0, 1'b1, 1'b1));

      for (phase = 0; phase < 6; phase++) begin
         settle();
         case (phase)
            0: setting = '0;
            1: setting = '1;
            2: begin
               setting.target_small  = EXP_SMALL_RST;
               setting.target_middle = EXP_MID_RST;
               setting.target_large  = EXP_LARGE_RST;
               setting.factor_small  = FAC_SMALL_RST;
               setting.factor_middle = FAC_MID_RST;
               setting.factor_large  = FAC_LARGE_RST;
            end
            default: begin
               setting.target_small  = pick_setting();
               setting.target_middle = pick_setting();
               setting.target_large  = pick_setting();
               setting.factor_small  = pick_setting();
               setting.factor_middle = pick_setting();
               setting.factor_large  = pick_setting();
            end
         endcase
         program_box(setting);
         calm <= (phase == 4);
         target = items_sent + PHASE_POINTS;
         // One long set of single points drives the cluster index into saturation.
         if (phase == 3) begin
            for (j = 0; j < 270; j++) send_cluster(1, j == 269, CLOUD_WILD);
         end
         while (items_sent < target) send_set($urandom_range(8, 1));
      end
      settle();

      $display("Run covered %0d points, %0d cluster results and %0d closed sets",
               points_seen_total, boxes_checked, sets_closed);
      $display("over the reset box, all-zero, all-ones and three random register settings.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS box_dimension_template_matcher");
      end else begin
         $display("FAIL box_dimension_template_matcher");
      end
      $finish;
   end

endmodule

@@ box_dimension_template_matcher.f @@
hw/rtl/bdtm_pkg.sv
hw/rtl/bdtm_accum.sv
hw/rtl/bdtm_score.sv
hw/rtl/bdtm_select.sv
hw/rtl/box_dimension_template_matcher.sv
tb/sv/box_match_checker.sv
tb/sv/tb.sv
